[sv/fftbtg_pkg.sv]
// ----------------------------------------------------------------------------
// fftbtg_pkg
// Shared widths, latency and the elaboration-time quarter-wave sine builder
// for the radix-2 FFT butterfly index and twiddle generator.
// ----------------------------------------------------------------------------
package fftbtg_pkg;

	localparam int STAGE_W = 4;
	localparam int POS_W   = 10;
	localparam int CFG_W   = 4;
	localparam int IDX_W   = 10;
	localparam int TW_W    = 16;
	localparam int LATENCY = 4;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// Entry t of the quarter-wave sine table, built by a Q30 Taylor series.
	// This runs only at elaboration to fill the constant table.
	function automatic longint quarter_sine(int t, int max_log2, int frac_bits);
		logic [127:0] quarter;
		logic [127:0] ang;
		logic [127:0] x;
		logic [127:0] x2;
		logic [127:0] term;
		longint sum;
		longint r;
		quarter = 128'd1 << (max_log2 - 2);
		if (t == 0) begin
			return 64'sd0;
		end
		if (128'(t) >= quarter) begin
			return 64'sd1 <<< frac_bits;
		end
		ang = 128'(t) * 128'd2 * 128'(PI_Q30) + (128'd1 << (max_log2 - 1));
		x = ang >> max_log2;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x[63:0]);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / 128'((2 * n) * (2 * n + 1));
			if ((n & 1) == 1) begin
				sum = sum - signed'(term[63:0]);
			end else begin
				sum = sum + signed'(term[63:0]);
			end
		end
		if (sum < 64'sd0) begin
			sum = 64'sd0;
		end
		if (sum > (64'sd1 <<< 30)) begin
			sum = 64'sd1 <<< 30;
		end
		if (frac_bits < 30) begin
			r = (sum + (64'sd1 <<< (29 - frac_bits))) >>> (30 - frac_bits);
		end else begin
			r = sum;
		end
		return r;
	endfunction

	function automatic logic signed [TW_W-1:0] sat_tw(logic signed [32:0] v);
		if (v > 33'sd32767) begin
			return 16'sh7fff;
		end else if (v < -33'sd32768) begin
			return 16'sh8000;
		end else begin
			return signed'(v[TW_W-1:0]);
		end
	endfunction

endpackage

[sv/fftbtg_twiddle_rom.sv]
// ----------------------------------------------------------------------------
// fftbtg_twiddle_rom
// Quarter-wave sine table with two registered read ports, one for the
// cosine address and one for the sine address.
// ----------------------------------------------------------------------------
module fftbtg_twiddle_rom #(
	parameter int MAX_LOG2_SIZE     = 10,
	parameter int TWIDDLE_FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic [MAX_LOG2_SIZE-2:0]     rd_addr_a,
	input  logic [MAX_LOG2_SIZE-2:0]     rd_addr_b,
	output logic [TWIDDLE_FRAC_BITS:0]   rd_data_a,
	output logic [TWIDDLE_FRAC_BITS:0]   rd_data_b
);
	import fftbtg_pkg::*;

	localparam int DEPTH = (1 << (MAX_LOG2_SIZE - 2)) + 1;
	localparam int DW    = TWIDDLE_FRAC_BITS + 1;

	logic [DW-1:0] rom [DEPTH];

	for (genvar t = 0; t < DEPTH; t++) begin : g_rom
		localparam logic [DW-1:0] ENTRY =
			DW'(quarter_sine(t, MAX_LOG2_SIZE, TWIDDLE_FRAC_BITS));
		assign rom[t] = ENTRY;
	end

	always_ff @(posedge clk) begin
		rd_data_a <= rom[rd_addr_a];
		rd_data_b <= rom[rd_addr_b];
	end

endmodule

[sv/fft_butterfly_index_twiddle_gen.sv]
// ----------------------------------------------------------------------------
// fft_butterfly_index_twiddle_gen
// An accepted start passes through the valid registers v_s1 to v_s4 to the done strobe.
// Throughput is one word per cycle; busy stays low since every stage advances
// each cycle and the receiver cannot stall.
// Reset clears the stage valid bits and sets the transform size to 2^10.
// ----------------------------------------------------------------------------
module fft_butterfly_index_twiddle_gen #(
	parameter int MAX_LOG2_SIZE     = 10,
	parameter int TWIDDLE_FRAC_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [fftbtg_pkg::CFG_W-1:0]         cfg_wr_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [fftbtg_pkg::STAGE_W-1:0]       stage,
	input  logic [fftbtg_pkg::POS_W-1:0]         position,
	output logic                                 done,
	output logic [fftbtg_pkg::IDX_W-1:0]         first_index,
	output logic [fftbtg_pkg::IDX_W-1:0]         second_index,
	output logic signed [fftbtg_pkg::TW_W-1:0]   twiddle_real,
	output logic signed [fftbtg_pkg::TW_W-1:0]   twiddle_imag
);
	import fftbtg_pkg::*;

	localparam int AW   = MAX_LOG2_SIZE;
	localparam int LW   = $clog2(MAX_LOG2_SIZE + 1);
	localparam int SW   = $clog2(MAX_LOG2_SIZE);
	localparam int RA_W = MAX_LOG2_SIZE - 1;
	localparam int DW   = TWIDDLE_FRAC_BITS + 1;

	localparam logic [CFG_W-1:0] RESET_LOG2 = CFG_W'(10);
	localparam logic [AW-1:0]    QUARTER    = AW'(1) << (AW - 2);
	localparam logic [AW-1:0]    HALF       = AW'(1) << (AW - 1);

	logic [CFG_W-1:0] log2_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_size_q <= RESET_LOG2;
		end else if (cfg_wr_en) begin
			log2_size_q <= cfg_wr_data;
		end
	end

	assign busy = 1'b0;

	// Stage 1: clamp size and stage, mask the position.
	logic [4:0]            len_w;
	logic [4:0]            stage_w;
	logic [AW+POS_W-1:0]   pos_ext;
	logic [LW-1:0]         len_c;
	logic [SW-1:0]         s_c;
	logic [AW-1:0]         p_c;

	always_comb begin
		len_w = {1'b0, log2_size_q};
		if (len_w == 5'd0) begin
			len_w = 5'd1;
		end else if (len_w > 5'(MAX_LOG2_SIZE)) begin
			len_w = 5'(MAX_LOG2_SIZE);
		end
		stage_w = {1'b0, stage};
		if (stage_w > len_w - 5'd1) begin
			stage_w = len_w - 5'd1;
		end
		len_c   = LW'(len_w);
		s_c     = SW'(stage_w);
		pos_ext = (AW + POS_W)'(position);
		p_c     = pos_ext[AW-1:0] & ~({AW{1'b1}} << len_c);
	end

	logic          v_s1;
	logic [LW-1:0] len_s1;
	logic [SW-1:0] s_s1;
	logic [AW-1:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		len_s1 <= len_c;
		s_s1   <= s_c;
		p_s1   <= p_c;
	end

	// Stage 2: operand indices, bit reversal and table addresses.
	logic [AW-1:0]   bit_c;
	logic            upper_c;
	logic [AW-1:0]   lo_c;
	logic [AW-1:0]   hi_c;
	logic [AW-1:0]   lo_rev;
	logic [AW-1:0]   hi_rev;
	logic [LW-1:0]   rev_sh;
	logic [AW-1:0]   lo_fin;
	logic [AW-1:0]   hi_fin;
	logic [AW-1:0]   k_c;
	logic [AW-1:0]   a_c;
	logic [RA_W-1:0] c_addr_c;
	logic [RA_W-1:0] s_addr_c;
	logic            negc_c;

	always_comb begin
		bit_c   = AW'(1) << s_s1;
		upper_c = |(p_s1 & bit_c);
		lo_c    = p_s1 & ~bit_c;
		hi_c    = lo_c | bit_c;
		for (int i = 0; i < AW; i++) begin
			lo_rev[AW-1-i] = lo_c[i];
			hi_rev[AW-1-i] = hi_c[i];
		end
		rev_sh = LW'(AW) - len_s1;
		if (s_s1 == '0) begin
			lo_fin = lo_rev >> rev_sh;
			hi_fin = hi_rev >> rev_sh;
		end else begin
			lo_fin = lo_c;
			hi_fin = hi_c;
		end
		k_c = p_s1 & (bit_c - AW'(1));
		a_c = k_c << (SW'(AW - 1) - s_s1);
		if (a_c <= QUARTER) begin
			c_addr_c = RA_W'(QUARTER - a_c);
			s_addr_c = RA_W'(a_c);
			negc_c   = 1'b0;
		end else begin
			c_addr_c = RA_W'(a_c - QUARTER);
			s_addr_c = RA_W'(HALF - a_c);
			negc_c   = 1'b1;
		end
	end

	logic            v_s2;
	logic [AW-1:0]   lo_s2;
	logic [AW-1:0]   hi_s2;
	logic            upper_s2;
	logic            negc_s2;
	logic [RA_W-1:0] c_addr_s2;
	logic [RA_W-1:0] s_addr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		lo_s2     <= lo_fin;
		hi_s2     <= hi_fin;
		upper_s2  <= upper_c;
		negc_s2   <= negc_c;
		c_addr_s2 <= c_addr_c;
		s_addr_s2 <= s_addr_c;
	end

	// Stage 3: table read.
	logic          v_s3;
	logic [AW-1:0] lo_s3;
	logic [AW-1:0] hi_s3;
	logic          neg_re_s3;
	logic          neg_im_s3;
	logic [DW-1:0] rom_c_s3;
	logic [DW-1:0] rom_s_s3;

	fftbtg_twiddle_rom #(
		.MAX_LOG2_SIZE     (MAX_LOG2_SIZE),
		.TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
	) u_rom (
		.clk       (clk),
		.rd_addr_a (c_addr_s2),
		.rd_addr_b (s_addr_s2),
		.rd_data_a (rom_c_s3),
		.rd_data_b (rom_s_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		lo_s3     <= lo_s2;
		hi_s3     <= hi_s2;
		neg_re_s3 <= negc_s2 ^ upper_s2;
		neg_im_s3 <= upper_s2;
	end

	// Stage 4: sign, saturation and output register.
	logic signed [32:0]    re_ext;
	logic signed [32:0]    im_ext;
	logic signed [32:0]    re_val;
	logic signed [32:0]    im_val;
	logic [AW+IDX_W-1:0]   lo_ext;
	logic [AW+IDX_W-1:0]   hi_ext;

	always_comb begin
		re_ext = signed'(33'(rom_c_s3));
		im_ext = signed'(33'(rom_s_s3));
		re_val = neg_re_s3 ? -re_ext : re_ext;
		im_val = neg_im_s3 ? -im_ext : im_ext;
		lo_ext = (AW + IDX_W)'(lo_s3);
		hi_ext = (AW + IDX_W)'(hi_s3);
	end

	logic                   v_s4;
	logic [IDX_W-1:0]       first_s4;
	logic [IDX_W-1:0]       second_s4;
	logic signed [TW_W-1:0] re_s4;
	logic signed [TW_W-1:0] im_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s4  <= lo_ext[IDX_W-1:0];
		second_s4 <= hi_ext[IDX_W-1:0];
		re_s4     <= sat_tw(re_val);
		im_s4     <= sat_tw(im_val);
	end

	assign done         = v_s4;
	assign first_index  = first_s4;
	assign second_index = second_s4;
	assign twiddle_real = re_s4;
	assign twiddle_imag = im_s4;

endmodule

[sv/fftbtg_checker.sv]
// ----------------------------------------------------------------------------
// fftbtg_checker
// Port-level checks on the butterfly index and twiddle generator, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module fftbtg_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic [fftbtg_pkg::POS_W-1:0]         position,
	input logic                                 done,
	input logic [fftbtg_pkg::IDX_W-1:0]         first_index,
	input logic signed [fftbtg_pkg::TW_W-1:0]   twiddle_real,
	input logic signed [fftbtg_pkg::TW_W-1:0]   twiddle_imag
);
	import fftbtg_pkg::*;

	// Every accepted word produces its result a fixed number of cycles later.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word did not complete after the pipeline latency");

	// No result appears without a word accepted at the matching earlier edge.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result word without a matching accepted word");

	// A twiddle is a point on the unit circle, so it is never zero.
	a_twiddle_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (twiddle_real != 0 || twiddle_imag != 0))
		else $error("twiddle factor is zero");

	// Position zero always uses the unit twiddle and the first element.
	a_position_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && position == '0 |-> ##LATENCY
			(first_index == '0 && twiddle_imag == 0 && twiddle_real > 0))
		else $error("position zero did not give the unit twiddle");

endmodule

bind fft_butterfly_index_twiddle_gen fftbtg_checker u_fftbtg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.position     (position),
	.done         (done),
	.first_index  (first_index),
	.twiddle_real (twiddle_real),
	.twiddle_imag (twiddle_imag)
);
